// ===== design/nps_pkg.sv =====
// Shared types and constants of the NAL parameter-set stripper.
package nps_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 3;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_ENABLE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_AVC_MODE     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEVC_MODE    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_SIZE  = 2'd3;

	localparam logic [7:0] AVC_TYPE_MASK  = 8'h1F;
	localparam logic [7:0] HEVC_TYPE_MASK = 8'h7E;
	localparam logic [2:0] MAX_PREFIX     = 3'd4;

	localparam logic [5:0] AVC_SPS  = 6'd7;
	localparam logic [5:0] AVC_PPS  = 6'd8;
	localparam logic [5:0] AVC_SPSX = 6'd13;
	localparam logic [5:0] HEVC_VPS = 6'd32;
	localparam logic [5:0] HEVC_SPS = 6'd33;
	localparam logic [5:0] HEVC_PPS = 6'd34;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [23:0] sample_length;
	} sample_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       route;
		logic [5:0] unit_type;
		logic       unit_start;
		logic       sample_end;
	} result_word_t;

	typedef struct packed {
		logic       strip_enable;
		logic       avc_mode;
		logic       hevc_mode;
		logic [2:0] length_size;
	} cfg_t;

	// One accepted byte's worth of results: up to five bytes, oldest in the top byte.
	// All results share route and type; only the first may start a unit.
	typedef struct packed {
		logic [39:0] bytes;
		logic [2:0]  count;
		logic        route;
		logic [5:0]  unit_type;
		logic        start;
		logic        last;
	} rec_t;

endpackage

// ===== design/nps_front.sv =====
// Front end: parses prefixes and headers and builds at most one result record per accepted byte.
module nps_front import nps_pkg::*; #(
	parameter int SAMPLE_LEN_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         accept,
	input  sample_word_t word,
	output logic         push,
	output rec_t         rec
);

	localparam int SLB = SAMPLE_LEN_BITS;

	logic [SLB-1:0] pos_q, pos_n;
	logic [31:0]    prefix_q, prefix_n;
	logic [2:0]     count_q, count_n;
	logic [SLB-1:0] left_q, left_n;
	logic           route_q, route_n;
	logic [5:0]     type_q, type_n;
	logic           pass_q, pass_n;

	logic [7:0]     b;
	logic [SLB-1:0] slen;
	logic           final_byte;
	logic [2:0]     ls;
	logic [31:0]    prefix_shift;
	logic [2:0]     count_inc;
	logic [31:0]    size;
	logic [33:0]    unit_end;
	logic           overrun;
	logic [5:0]     hdr_type;
	logic           is_ps;
	logic [31:0]    buf_sel;
	logic [2:0]     held;

	assign b    = word.data_byte;
	assign slen = SLB'({8'b0, word.sample_length});
	assign final_byte = ({1'b0, pos_q} + {{SLB{1'b0}}, 1'b1}) >= {1'b0, slen};

	always_comb begin
		if (cfg.length_size == 3'd0) begin
			ls = 3'd1;
		end else if (cfg.length_size > MAX_PREFIX) begin
			ls = MAX_PREFIX;
		end else begin
			ls = cfg.length_size;
		end
	end

	assign prefix_shift = {prefix_q[23:0], b};
	assign count_inc    = count_q + 3'd1;

	always_comb begin
		case (ls)
			3'd1:    size = {24'b0, prefix_shift[7:0]};
			3'd2:    size = {16'b0, prefix_shift[15:0]};
			3'd3:    size = {8'b0, prefix_shift[23:0]};
			default: size = prefix_shift;
		endcase
	end

	assign unit_end = {2'b0, size} + 34'(pos_q) + 34'd1;
	assign overrun  = unit_end > 34'(slen);

	// header classification; the HEVC type wins when both modes are set
	always_comb begin
		hdr_type = 6'd0;
		is_ps    = 1'b0;
		if (cfg.avc_mode) begin
			hdr_type = 6'(b & AVC_TYPE_MASK);
			if (hdr_type == AVC_SPS || hdr_type == AVC_PPS || hdr_type == AVC_SPSX) begin
				is_ps = 1'b1;
			end
		end
		if (cfg.hevc_mode) begin
			hdr_type = 6'((b & HEVC_TYPE_MASK) >> 1);
			if (hdr_type == HEVC_VPS || hdr_type == HEVC_SPS || hdr_type == HEVC_PPS) begin
				is_ps = 1'b1;
			end
		end
	end

	always_comb begin
		pos_n    = pos_q;
		prefix_n = prefix_q;
		count_n  = count_q;
		left_n   = left_q;
		route_n  = route_q;
		type_n   = type_q;
		pass_n   = pass_q;
		push     = 1'b0;
		buf_sel  = prefix_q;
		held     = 3'd0;
		rec.count     = 3'd1;
		rec.route     = 1'b0;
		rec.unit_type = 6'd0;
		rec.start     = 1'b0;
		rec.last      = final_byte;
		if (pass_q) begin
			push = 1'b1;
		end else if (pos_q == '0 && !(cfg.strip_enable && (cfg.avc_mode || cfg.hevc_mode))) begin
			push      = 1'b1;
			rec.start = 1'b1;
			pass_n    = 1'b1;
		end else if (left_q == '0) begin
			prefix_n  = prefix_shift;
			count_n   = count_inc;
			buf_sel   = prefix_shift;
			held      = count_inc;
			rec.count = count_inc;
			rec.start = 1'b1;
			if (count_inc >= ls) begin
				if (overrun || size == 32'd0) begin
					push     = 1'b1;
					pass_n   = overrun;
					prefix_n = 32'd0;
					count_n  = 3'd0;
				end else begin
					left_n = size[SLB-1:0];
				end
			end else if (final_byte) begin
				push = 1'b1;
			end
		end else if (count_q != 3'd0) begin
			push          = 1'b1;
			type_n        = hdr_type;
			route_n       = is_ps;
			rec.unit_type = hdr_type;
			rec.start     = 1'b1;
			if (is_ps) begin
				rec.route = 1'b1;
			end else begin
				held      = count_q;
				rec.count = count_inc;
			end
			prefix_n = 32'd0;
			count_n  = 3'd0;
			left_n   = left_q - {{(SLB-1){1'b0}}, 1'b1};
		end else begin
			push          = 1'b1;
			rec.route     = route_q;
			rec.unit_type = type_q;
			left_n        = left_q - {{(SLB-1){1'b0}}, 1'b1};
		end
		if (final_byte) begin
			pos_n    = '0;
			prefix_n = 32'd0;
			count_n  = 3'd0;
			left_n   = '0;
			route_n  = 1'b0;
			type_n   = 6'd0;
			pass_n   = 1'b0;
		end else begin
			pos_n = pos_q + {{(SLB-1){1'b0}}, 1'b1};
		end
		push = push && accept;
		// held prefix bytes first, then the current byte
		case (held)
			3'd0:    rec.bytes = {b, 32'b0};
			3'd1:    rec.bytes = {buf_sel[7:0], b, 24'b0};
			3'd2:    rec.bytes = {buf_sel[15:0], b, 16'b0};
			3'd3:    rec.bytes = {buf_sel[23:0], b, 8'b0};
			default: rec.bytes = {buf_sel, b};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prefix_q <= 32'd0;
			count_q  <= 3'd0;
			left_q   <= '0;
			route_q  <= 1'b0;
			type_q   <= 6'd0;
			pass_q   <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_n;
			prefix_q <= prefix_n;
			count_q  <= count_n;
			left_q   <= left_n;
			route_q  <= route_n;
			type_q   <= type_n;
			pass_q   <= pass_n;
		end
	end

endmodule

// ===== design/nps_queue.sv =====
// Short record queue between the front end and the output serializer.
module nps_queue import nps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output logic nonempty,
	output logic full,
	output rec_t head
);

	rec_t                 slots [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [QUEUE_PTR_W:0]   fill_q;

	assign nonempty = fill_q != '0;
	assign full     = fill_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
	assign head     = slots[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QUEUE_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QUEUE_PTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QUEUE_PTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== design/nps_back.sv =====
// Back end: unpacks records into single result words behind an output register.
module nps_back import nps_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_nonempty,
	input  rec_t         q_head,
	output logic         q_pop,
	output logic         result_valid,
	input  logic         result_ready,
	output result_word_t result_word
);

	rec_t         cur_q;
	logic         cur_valid_q;
	logic         advance;
	logic         emit;
	logic         reload;
	result_word_t word_n;

	assign advance = !result_valid || result_ready;
	assign emit    = cur_valid_q && advance;
	// take the next record when the current one is spent or absent
	assign reload  = q_nonempty && (!cur_valid_q || (emit && cur_q.count == 3'd1));
	assign q_pop   = reload;

	always_comb begin
		word_n.out_byte   = cur_q.bytes[39:32];
		word_n.route      = cur_q.route;
		word_n.unit_type  = cur_q.unit_type;
		word_n.unit_start = cur_q.start;
		word_n.sample_end = cur_q.last && cur_q.count == 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (reload) begin
				cur_valid_q <= 1'b1;
			end else if (emit && cur_q.count == 3'd1) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_word <= word_n;
		end
		if (reload) begin
			cur_q <= q_head;
		end else if (emit) begin
			cur_q.bytes <= {cur_q.bytes[31:0], 8'b0};
			cur_q.count <= cur_q.count - 3'd1;
			cur_q.start <= 1'b0;
		end
	end

endmodule

// ===== design/nal_parameter_set_stripper.sv =====
// Top level of the NAL parameter-set stripper: config registers, front end, queue, back end.
// Path: each result passes the record queue, the current-record register and the output register.
// Throughput: one word per cycle while each word yields at most one result and result_ready is high;
// a word that yields k results (held prefix bytes plus its own byte) keeps the output register busy
// while they drain, and the four-entry record queue absorbs those bursts before the input stalls.
// Reset: arst_n clears all parse state, queue and output valid at once and loads config defaults.
module nal_parameter_set_stripper import nps_pkg::*; #(
	parameter int SAMPLE_LEN_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  sample_word_t           sample_word,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_word_t           result_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	logic accept;
	logic q_push;
	rec_t q_rec;
	logic q_pop;
	logic q_nonempty;
	logic q_full;
	rec_t q_head;

	// Configuration registers; to be written only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strip_enable <= 1'b1;
			cfg_q.avc_mode     <= 1'b0;
			cfg_q.hevc_mode    <= 1'b0;
			cfg_q.length_size  <= MAX_PREFIX;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STRIP_ENABLE: cfg_q.strip_enable <= cfg_data[0];
				CFG_AVC_MODE:     cfg_q.avc_mode     <= cfg_data[0];
				CFG_HEVC_MODE:    cfg_q.hevc_mode    <= cfg_data[0];
				CFG_LENGTH_SIZE:  cfg_q.length_size  <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	// Take a word whenever the queue has room; a word with no result pushes nothing.
	assign sample_ready = !q_full;
	assign accept       = sample_valid && sample_ready;

	// Front end: hold prefix bytes until the header decides the unit's fate,
	// drop the prefix of a parameter set, pass overruns and unparsed samples.
	nps_front #(
		.SAMPLE_LEN_BITS(SAMPLE_LEN_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.word   (sample_word),
		.push   (q_push),
		.rec    (q_rec)
	);

	// Record queue: lets the parser run ahead while the serializer drains a burst.
	nps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_rec),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.full     (q_full),
		.head     (q_head)
	);

	// Back end: advance one result word per cycle into the output register unless the output is stalled.
	nps_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

`ifndef NO_ASSERTIONS
	// the front end never writes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("record pushed into full queue");

	// every pushed record carries one to five results
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_rec.count != 3'd0 && q_rec.count <= 3'd5))
		else $error("pushed record with bad result count");

	// a stalled result word holds valid and payload until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_word)))
		else $error("stalled result word changed");

	// the serializer never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_nonempty)
		else $error("pop from empty queue");
`endif

endmodule
